// ===== rtl/core/sos_pkg.sv =====
// Shared types, constants and the soft limiter curve for the stereo master output stage.
// Depends on nothing; every other file in rtl/core imports it.
package sos_pkg;

	localparam int SAMPLE_BITS = 24;
	localparam int FRAC = SAMPLE_BITS - 1;
	localparam int ACC_W = 2 * SAMPLE_BITS;
	localparam int PEAK_W = FRAC;

	localparam longint SMAX = (longint'(1) << FRAC) - 1;
	localparam longint SMIN = -(longint'(1) << FRAC);

	localparam int IN_TDATA_W = 2 * SAMPLE_BITS;
	localparam int OUT_FIELDS_W = 2 * SAMPLE_BITS + 2 * PEAK_W;
	localparam int OUT_TDATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;

	localparam int VINT_W = 17;
	localparam int GAIN_W = 19;
	localparam int WIDTH_W = 18;
	localparam int DECAY_W = 24;
	localparam int K_W = 16;
	localparam int C_W = 17;
	localparam int GAIN_FRAC = 16;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 24;

	localparam longint VINT_ON = 656;
	localparam int KN_W = 19;
	localparam longint KDIV_M = 419431;
	localparam int KDIV_S = 22;
	localparam int KDIV_MW = $clog2(KDIV_M + 1);
	localparam longint C_ONE = longint'(1) << GAIN_FRAC;

	localparam longint GAIN_RESET = 46341;
	localparam longint WIDTH_RESET = 32768;
	localparam longint DECAY_RESET = 16776051;

	localparam longint LIM_T = (longint'(9) << FRAC) / 10;
	localparam longint LIM_D = (longint'(1) << FRAC) - LIM_T;
	localparam longint LIM_D_HALF = LIM_D / 2;
	localparam int LIM_DEPTH = 256;
	localparam int LIM_IDX_W = $clog2(LIM_DEPTH);
	localparam int D_W = $clog2(LIM_D + 1);
	localparam int TAB_W = D_W;
	localparam int N_W = $clog2(LIM_D * LIM_DEPTH);
	localparam longint LIM_M = ((longint'(1) << N_W) + LIM_D - 1) / LIM_D;
	localparam int M_W = $clog2(LIM_M + 1);
	localparam int CHK_W = M_W + D_W;

	localparam int Q_DEPTH = 2;
	localparam int QA_W = $clog2(Q_DEPTH);

	typedef logic signed [SAMPLE_BITS-1:0] smp_t;

	typedef struct packed {
		logic smooth_on;
		smp_t left;
		smp_t right;
	} item_t;

	typedef struct packed {
		logic                vintage_on;
		logic [C_W-1:0]      c;
		logic [GAIN_W-1:0]   gain_left;
		logic [GAIN_W-1:0]   gain_right;
		logic [WIDTH_W-1:0]  stereo_width;
		logic [DECAY_W-1:0]  meter_decay;
	} cfg_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_VINTAGE    = 3'd0,
		CFG_GAIN_LEFT  = 3'd1,
		CFG_GAIN_RIGHT = 3'd2,
		CFG_WIDTH      = 3'd3,
		CFG_DECAY      = 3'd4
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_VMUL,
		ST_VSUM,
		ST_GMUL,
		ST_GSUM,
		ST_WMUL,
		ST_WSUM,
		ST_LABS,
		ST_LMUL,
		ST_LCHK,
		ST_LSEL,
		ST_MET
	} state_t;

	typedef logic [TAB_W-1:0] lim_tab_t [LIM_DEPTH];

	// Shift-and-subtract quotient, used only while the limiter table is built.
	function automatic longint unsigned const_udiv(longint unsigned num, longint unsigned den);
		longint unsigned quo;
		longint unsigned rem;
		int b;
		quo = '0;
		rem = '0;
		for (b = 63; b >= 0; b--) begin
			rem = {rem[62:0], num[b]};
			if (rem >= den) begin
				rem = rem - den;
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	// Each entry already holds the tanh knee scaled by one tenth and rounded.
	function automatic lim_tab_t build_lim_tab();
		lim_tab_t tab;
		longint unsigned one;
		longint unsigned e2;
		longint unsigned term;
		longint unsigned sum;
		longint unsigned num;
		longint unsigned w;
		longint unsigned z;
		longint unsigned th;
		int i;
		int n;
		one = longint'(1) << 28;
		for (i = 0; i < LIM_DEPTH; i++) begin
			num = longint'(10) * longint'(i) * longint'(LIM_D);
			w = const_udiv(num << 16, longint'(LIM_DEPTH - 1));
			z = w >> (FRAC - 12);
			e2 = z * 2;
			term = one;
			sum = one;
			for (n = 1; n < 48 && term != 0; n++) begin
				term = const_udiv((term * e2) >> 28, longint'(n));
				sum = sum + term;
			end
			th = const_udiv((sum - one) << FRAC, sum + one);
			tab[i] = TAB_W'(const_udiv(th + 5, 64'd10));
		end
		return tab;
	endfunction

	localparam lim_tab_t LIM_TAB = build_lim_tab();

endpackage

// ===== rtl/core/sos_cfg.sv =====
// Configuration register file of the stereo master output stage.
// Depends on sos_pkg; also derives the smoother coefficient when the amount is written.
module sos_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [sos_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [sos_pkg::CFG_DATA_W-1:0]    cfg_data,
	output sos_pkg::cfg_t                     cfg
);
	import sos_pkg::*;

	cfg_t                       cfg_q;
	logic [VINT_W-1:0]          wv;
	logic [KN_W-1:0]            kn;
	logic [KN_W+KDIV_MW-1:0]    kp;
	logic [K_W-1:0]             k;
	logic                       wr;

	assign cfg_ready = 1'b1;
	assign wr = cfg_valid && cfg_ready;
	assign cfg = cfg_q;

	// The rolloff coefficient is round(0.3 * amount), with the divide by ten done by reciprocal.
	assign wv = cfg_data[VINT_W-1:0];
	assign kn = KN_W'(wv) * KN_W'(3) + KN_W'(5);
	assign kp = (KN_W+KDIV_MW)'(kn) * (KN_W+KDIV_MW)'(KDIV_M);
	assign k = kp[KDIV_S +: K_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.vintage_on <= 1'b0;
			cfg_q.c <= C_W'(C_ONE);
			cfg_q.gain_left <= GAIN_W'(GAIN_RESET);
			cfg_q.gain_right <= GAIN_W'(GAIN_RESET);
			cfg_q.stereo_width <= WIDTH_W'(WIDTH_RESET);
			cfg_q.meter_decay <= DECAY_W'(DECAY_RESET);
		end else if (wr) begin
			case (cfg_idx_t'(cfg_index))
				CFG_VINTAGE: begin
					cfg_q.vintage_on <= (longint'(wv) >= VINT_ON);
					cfg_q.c <= C_W'(C_ONE) - C_W'(k);
				end
				CFG_GAIN_LEFT: begin
					cfg_q.gain_left <= cfg_data[GAIN_W-1:0];
				end
				CFG_GAIN_RIGHT: begin
					cfg_q.gain_right <= cfg_data[GAIN_W-1:0];
				end
				CFG_WIDTH: begin
					cfg_q.stereo_width <= cfg_data[WIDTH_W-1:0];
				end
				CFG_DECAY: begin
					cfg_q.meter_decay <= cfg_data[DECAY_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// ===== rtl/core/sos_front.sv =====
// Input side of the stereo master output stage: takes sample requests and tags them.
// Depends on sos_pkg; feeds sos_queue.
module sos_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// left_in [23:0], right_in [47:24]
	input  logic [sos_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
	input  sos_pkg::cfg_t                     cfg,
	output logic                              push,
	output sos_pkg::item_t                    push_item,
	input  logic                              q_full
);
	import sos_pkg::*;

	item_t item_s1;
	logic  valid_s1;
	logic  accept;

	assign push = valid_s1 && !q_full;
	assign s_axis_tready = !valid_s1 || push;
	assign accept = s_axis_tvalid && s_axis_tready;
	assign push_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	// Each request is marked with whether the rolloff smoother applies to it.
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.smooth_on <= cfg.vintage_on;
			item_s1.left <= s_axis_tdata[SAMPLE_BITS-1:0];
			item_s1.right <= s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
		end
	end

endmodule

// ===== rtl/core/sos_queue.sv =====
// Short register queue between the input side and the processing sequencer.
// Depends on sos_pkg for the item type and depth.
module sos_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  sos_pkg::item_t  push_item,
	output logic            full,
	input  logic            pop,
	output sos_pkg::item_t  pop_item,
	output logic            empty
);
	import sos_pkg::*;

	item_t             mem_q [Q_DEPTH];
	logic [QA_W-1:0]   wr_ptr_q;
	logic [QA_W-1:0]   rd_ptr_q;
	logic [QA_W:0]     count_q;
	logic              do_push;
	logic              do_pop;

	assign full = (count_q == (QA_W+1)'(Q_DEPTH));
	assign empty = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign pop_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// ===== rtl/core/sos_back.sv =====
// Processing sequencer: smoother, gain, mid/side width, soft limiter and peak meters.
// Depends on sos_pkg; drains sos_queue and owns the output register.
module sos_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  sos_pkg::cfg_t                     cfg,
	input  logic                              q_empty,
	output logic                              pop,
	input  sos_pkg::item_t                    pop_item,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// left_out [23:0], right_out [47:24], peak_left [70:48], peak_right [93:71]
	output logic [sos_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
	import sos_pkg::*;

	localparam int VD_W = SAMPLE_BITS + 1;
	localparam int VP_W = VD_W + C_W + 1;
	localparam int GP_W = SAMPLE_BITS + GAIN_W + 1;
	localparam int WP_W = VD_W + WIDTH_W + 1;
	localparam int MP_W = PEAK_W + DECAY_W;
	localparam int QP_W = N_W + M_W;
	localparam int OUT_PAD_W = OUT_TDATA_W - OUT_FIELDS_W;
	localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(SMAX);
	localparam logic signed [ACC_W-1:0] ACC_MIN = ACC_W'(SMIN);
	localparam logic signed [ACC_W-1:0] HALF_G = ACC_W'(1) <<< (GAIN_FRAC - 1);
	localparam logic signed [ACC_W-1:0] HALF_W = ACC_W'(1) <<< GAIN_FRAC;

	function automatic smp_t sat_smp(input logic signed [ACC_W-1:0] v);
		if (v > ACC_MAX) begin
			return SAMPLE_BITS'(SMAX);
		end else if (v < ACC_MIN) begin
			return SAMPLE_BITS'(SMIN);
		end
		return v[SAMPLE_BITS-1:0];
	endfunction

	state_t                     state_q;
	state_t                     state_d;
	logic                       out_load;
	logic                       out_free;
	logic                       out_valid_q;
	logic [OUT_TDATA_W-1:0]     out_data_q;

	smp_t                       smp_q [2];
	smp_t                       smooth_q [2];
	logic signed [ACC_W-1:0]    prod_q [2];
	logic [PEAK_W-1:0]          level_q [2];
	logic [MP_W-1:0]            mprod_q [2];
	logic                       over_q [2];
	logic [N_W-1:0]             n_q [2];
	logic [QP_W-1:0]            qp_q [2];
	logic [M_W-1:0]             qe_q [2];
	logic [CHK_W-1:0]           chk_q [2];

	logic [GAIN_W-1:0]          gain [2];
	logic signed [VD_W-1:0]     vdiff [2];
	logic signed [VP_W-1:0]     vprod [2];
	smp_t                       vnew [2];
	logic signed [GP_W-1:0]     gprod [2];
	smp_t                       gnew [2];
	logic signed [VD_W-1:0]     wdiff;
	logic signed [WP_W-1:0]     wprod;
	logic signed [ACC_W-1:0]    wsum;
	smp_t                       wl;
	smp_t                       wr;
	logic [SAMPLE_BITS-1:0]     lax [2];
	logic [SAMPLE_BITS-1:0]     ld [2];
	logic                       lover [2];
	logic [N_W-1:0]             ln [2];
	logic [QP_W-1:0]            lqp [2];
	logic [M_W-1:0]             lqe [2];
	logic [CHK_W-1:0]           lchk [2];
	logic [M_W-1:0]             lraw [2];
	logic [LIM_IDX_W-1:0]       lidx [2];
	logic [SAMPLE_BITS-1:0]     lmag [2];
	logic [SAMPLE_BITS-1:0]     lmsat [2];
	smp_t                       llim [2];
	logic [MP_W-1:0]            mprod [2];
	logic [PEAK_W-1:0]          mabs [2];
	logic [PEAK_W-1:0]          lnew [2];

	assign gain[0] = cfg.gain_left;
	assign gain[1] = cfg.gain_right;
	assign out_free = !out_valid_q || m_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_data_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (!q_empty) begin
					state_d = pop_item.smooth_on ? ST_VMUL : ST_GMUL;
				end
			end
			ST_VMUL: state_d = ST_VSUM;
			ST_VSUM: state_d = ST_GMUL;
			ST_GMUL: state_d = ST_GSUM;
			ST_GSUM: state_d = ST_WMUL;
			ST_WMUL: state_d = ST_WSUM;
			ST_WSUM: state_d = ST_LABS;
			ST_LABS: state_d = ST_LMUL;
			ST_LMUL: state_d = ST_LCHK;
			ST_LCHK: state_d = ST_LSEL;
			ST_LSEL: state_d = ST_MET;
			ST_MET: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		pop = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: pop = !q_empty;
			ST_MET: out_load = out_free;
			default: begin
			end
		endcase
	end

	// The smoother is evaluated as prev + (x - prev) * c so that one product per channel suffices.
	always_comb begin
		for (int ch = 0; ch < 2; ch++) begin
			vdiff[ch] = VD_W'(smp_q[ch]) - VD_W'(smooth_q[ch]);
			vprod[ch] = VP_W'(vdiff[ch]) * VP_W'($signed({1'b0, cfg.c}));
			vnew[ch] = sat_smp(((ACC_W'(smooth_q[ch]) <<< GAIN_FRAC) + prod_q[ch] + HALF_G)
				>>> GAIN_FRAC);
			gprod[ch] = GP_W'(smp_q[ch]) * GP_W'($signed({1'b0, gain[ch]}));
			gnew[ch] = sat_smp((prod_q[ch] + HALF_G) >>> GAIN_FRAC);

			lax[ch] = smp_q[ch][SAMPLE_BITS-1] ? SAMPLE_BITS'(-smp_q[ch])
				: SAMPLE_BITS'(smp_q[ch]);
			lover[ch] = lax[ch] > SAMPLE_BITS'(LIM_T);
			ld[ch] = lax[ch] - SAMPLE_BITS'(LIM_T);
			ln[ch] = N_W'(ld[ch][D_W-1:0]) * N_W'(LIM_DEPTH - 1) + N_W'(LIM_D_HALF);
			lqp[ch] = QP_W'(n_q[ch]) * QP_W'(LIM_M);
			lqe[ch] = qp_q[ch][QP_W-1 -: M_W];
			lchk[ch] = CHK_W'(lqe[ch]) * CHK_W'(LIM_D);
			lraw[ch] = (chk_q[ch] > CHK_W'(n_q[ch])) ? qe_q[ch] - 1'b1 : qe_q[ch];
			lidx[ch] = (lraw[ch] > M_W'(LIM_DEPTH - 1)) ? LIM_IDX_W'(LIM_DEPTH - 1)
				: lraw[ch][LIM_IDX_W-1:0];
			lmag[ch] = SAMPLE_BITS'(LIM_T) + SAMPLE_BITS'(LIM_TAB[lidx[ch]]);
			lmsat[ch] = (lmag[ch] > SAMPLE_BITS'(SMAX)) ? SAMPLE_BITS'(SMAX) : lmag[ch];
			if (!over_q[ch]) begin
				llim[ch] = smp_q[ch];
			end else if (smp_q[ch][SAMPLE_BITS-1]) begin
				llim[ch] = -$signed(lmsat[ch]);
			end else begin
				llim[ch] = $signed(lmsat[ch]);
			end

			mprod[ch] = MP_W'(level_q[ch]) * MP_W'(cfg.meter_decay);
			mabs[ch] = smp_q[ch][SAMPLE_BITS-1] ? PEAK_W'(-smp_q[ch]) : PEAK_W'(smp_q[ch]);
			lnew[ch] = (mabs[ch] > level_q[ch]) ? mabs[ch] : mprod_q[ch][MP_W-1 -: PEAK_W];
		end
		wdiff = VD_W'(smp_q[0]) - VD_W'(smp_q[1]);
		wprod = WP_W'(wdiff) * WP_W'($signed({1'b0, cfg.stereo_width}));
		wsum = (ACC_W'(smp_q[0]) + ACC_W'(smp_q[1])) <<< GAIN_FRAC;
		wl = sat_smp((wsum + prod_q[0] + HALF_W) >>> (GAIN_FRAC + 1));
		wr = sat_smp((wsum - prod_q[0] + HALF_W) >>> (GAIN_FRAC + 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
			for (int ch = 0; ch < 2; ch++) begin
				smooth_q[ch] <= '0;
				level_q[ch] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			for (int ch = 0; ch < 2; ch++) begin
				if (state_q == ST_VSUM) begin
					smooth_q[ch] <= vnew[ch];
				end
				if (out_load) begin
					level_q[ch] <= lnew[ch];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (pop) begin
					smp_q[0] <= pop_item.left;
					smp_q[1] <= pop_item.right;
				end
			end
			ST_VMUL: begin
				for (int ch = 0; ch < 2; ch++) begin
					prod_q[ch] <= ACC_W'(vprod[ch]);
				end
			end
			ST_VSUM: begin
				for (int ch = 0; ch < 2; ch++) begin
					smp_q[ch] <= vnew[ch];
				end
			end
			ST_GMUL: begin
				for (int ch = 0; ch < 2; ch++) begin
					prod_q[ch] <= ACC_W'(gprod[ch]);
				end
			end
			ST_GSUM: begin
				for (int ch = 0; ch < 2; ch++) begin
					smp_q[ch] <= gnew[ch];
				end
			end
			ST_WMUL: begin
				prod_q[0] <= ACC_W'(wprod);
			end
			ST_WSUM: begin
				smp_q[0] <= wl;
				smp_q[1] <= wr;
			end
			ST_LABS: begin
				for (int ch = 0; ch < 2; ch++) begin
					over_q[ch] <= lover[ch];
					n_q[ch] <= ln[ch];
					mprod_q[ch] <= mprod[ch];
				end
			end
			ST_LMUL: begin
				for (int ch = 0; ch < 2; ch++) begin
					qp_q[ch] <= lqp[ch];
				end
			end
			ST_LCHK: begin
				for (int ch = 0; ch < 2; ch++) begin
					qe_q[ch] <= lqe[ch];
					chk_q[ch] <= lchk[ch];
				end
			end
			ST_LSEL: begin
				for (int ch = 0; ch < 2; ch++) begin
					smp_q[ch] <= llim[ch];
				end
			end
			default: begin
			end
		endcase
		if (out_load) begin
			out_data_q <= {OUT_PAD_W'(0), lnew[1], lnew[0], smp_q[1], smp_q[0]};
		end
	end

endmodule

// ===== rtl/core/stereo_master_output_stage.sv =====
// Top level of the stereo master output stage.
// Depends on sos_pkg, sos_cfg, sos_front, sos_queue and sos_back.

// Each request carries one stereo pair in Q1.23 and yields one result with the limited pair and
// both peak meter levels. A sample passes an optional one-pole rolloff, per-channel gain, mid/side
// width and a table-driven soft limiter. The input register and a two-entry queue let the
// input side keep accepting while the sequencer works and a finished result waits. The sequencer
// works on one pair at a time and takes the next only once the last result has been loaded
// into the output register, so a stalled output side holds it. Configuration writes are
// taken every cycle and must only be made while no request is in flight.
module stereo_master_output_stage (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// left_in [23:0], right_in [47:24]
	input  logic [sos_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// left_out [23:0], right_out [47:24], peak_left [70:48], peak_right [93:71]
	output logic [sos_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [sos_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [sos_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import sos_pkg::*;

	cfg_t  cfg;
	logic  push;
	item_t push_item;
	logic  q_full;
	logic  pop;
	item_t pop_item;
	logic  q_empty;

	sos_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	sos_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.cfg           (cfg),
		.push          (push),
		.push_item     (push_item),
		.q_full        (q_full)
	);

	sos_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.pop_item  (pop_item),
		.empty     (q_empty)
	);

	sos_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.q_empty       (q_empty),
		.pop           (pop),
		.pop_item      (pop_item),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule

// ===== tb/stereo_master_output_stage_test.sv =====
// Self-checking testbench for the stereo master output stage: directed and random requests,
// random idling on both stream sides, and a bit-exact prediction of every result.
// Depends on sos_pkg and the stereo_master_output_stage RTL.
module stereo_master_output_stage_test;
	import sos_pkg::*;

	localparam longint KNEE = (longint'(9) << FRAC) / 10;
	localparam longint KNEE_SPAN = (longint'(1) << FRAC) - KNEE;
	localparam int CURVE_DEPTH = 256;
	localparam int ROLLOFF_ON = 656;
	localparam int UNITY = 65536;
	localparam int ROLLOFF_TOP = 65536;
	localparam int GAIN_TOP = 262144;
	localparam int WIDTH_TOP = 131072;
	localparam int DECAY_TOP = 16777215;
	localparam int GAIN_DEFAULT = 46341;
	localparam int WIDTH_DEFAULT = 32768;
	localparam int DECAY_DEFAULT = 16776051;

	typedef struct {
		logic [SAMPLE_BITS-1:0] left;
		logic [SAMPLE_BITS-1:0] right;
		logic [PEAK_W-1:0]      peak_l;
		logic [PEAK_W-1:0]      peak_r;
	} mix_result_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    s_axis_tvalid = 1'b0;
	logic                    s_axis_tready;
	logic [IN_TDATA_W-1:0]   s_axis_tdata = '0;
	logic                    m_axis_tvalid;
	logic                    m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0]  m_axis_tdata;
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [CFG_IDX_W-1:0]    cfg_index = '0;
	logic [CFG_DATA_W-1:0]   cfg_data = '0;

	logic [VINT_W-1:0]       rolloff_amt;
	logic [GAIN_W-1:0]       gain_l;
	logic [GAIN_W-1:0]       gain_r;
	logic [WIDTH_W-1:0]      width_amt;
	logic [DECAY_W-1:0]      decay_amt;
	smp_t                    mem_l;
	smp_t                    mem_r;
	logic [PEAK_W-1:0]       level_l;
	logic [PEAK_W-1:0]       level_r;
	longint                  knee_curve [CURVE_DEPTH];

	mix_result_t             pending_mixes [$];
	int                      mismatches = 0;
	int                      rx_wait = 0;
	int                      rx_hold = 0;
	bit                      rx_eager = 1'b0;
	bit                      tx_eager = 1'b0;

	stereo_master_output_stage dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #5 clk = ~clk;

	initial begin
		#3000000;
		$display("tb: failure");
		$finish;
	end

	function automatic longint tanh_q(longint unsigned z);
		longint unsigned unit_q;
		longint unsigned e2;
		longint unsigned term;
		longint unsigned acc;
		int n;
		unit_q = 64'd1 << 28;
		e2 = z * 2;
		term = unit_q;
		acc = unit_q;
		for (n = 1; n < 48 && term != 0; n++) begin
			term = ((term * e2) >> 28) / longint'(n);
			acc = acc + term;
		end
		return longint'(((acc - unit_q) << FRAC) / (acc + unit_q));
	endfunction

	function automatic void build_knee_curve();
		longint unsigned num;
		longint unsigned w;
		int i;
		for (i = 0; i < CURVE_DEPTH; i++) begin
			num = 10 * longint'(i) * longint'(KNEE_SPAN);
			w = (num << 16) / longint'(CURVE_DEPTH - 1);
			knee_curve[i] = tanh_q(w >> (FRAC - 12));
		end
	endfunction

	function automatic longint round_shift(longint v, int s);
		return (v + (longint'(1) << (s - 1))) >>> s;
	endfunction

	function automatic longint clip(longint v);
		if (v > SMAX)
			return SMAX;
		if (v < SMIN)
			return SMIN;
		return v;
	endfunction

	function automatic longint soft_clip(longint x);
		longint ax;
		longint d;
		longint idx;
		longint mag;
		ax = (x < 0) ? -x : x;
		if (ax <= KNEE)
			return x;
		d = ax - KNEE;
		idx = (d * (CURVE_DEPTH - 1) + KNEE_SPAN / 2) / KNEE_SPAN;
		if (idx > CURVE_DEPTH - 1)
			idx = CURVE_DEPTH - 1;
		mag = KNEE + (knee_curve[idx] + 5) / 10;
		if (mag > SMAX)
			mag = SMAX;
		return (x < 0) ? -mag : mag;
	endfunction

	function automatic logic [PEAK_W-1:0] meter_step(logic [PEAK_W-1:0] lvl, longint y);
		longint a;
		a = (y < 0) ? -y : y;
		if (a > longint'(lvl))
			return PEAK_W'(a);
		return PEAK_W'((longint'(lvl) * longint'(decay_amt)) >> 24);
	endfunction

	function automatic mix_result_t predict_mix(smp_t l_in, smp_t r_in);
		mix_result_t res;
		longint l;
		longint r;
		longint k;
		longint c;
		longint mid;
		longint side;
		longint lo;
		longint ro;
		l = l_in;
		r = r_in;
		if (rolloff_amt >= ROLLOFF_ON) begin
			k = (3 * longint'(rolloff_amt) + 5) / 10;
			c = UNITY - k;
			l = clip(round_shift(l * c + longint'(mem_l) * k, 16));
			r = clip(round_shift(r * c + longint'(mem_r) * k, 16));
			mem_l = smp_t'(l);
			mem_r = smp_t'(r);
		end
		l = clip(round_shift(l * longint'(gain_l), 16));
		r = clip(round_shift(r * longint'(gain_r), 16));
		mid = (l + r) * UNITY;
		side = (l - r) * longint'(width_amt);
		lo = soft_clip(clip(round_shift(mid + side, 17)));
		ro = soft_clip(clip(round_shift(mid - side, 17)));
		level_l = meter_step(level_l, lo);
		level_r = meter_step(level_r, ro);
		res.left = SAMPLE_BITS'(lo);
		res.right = SAMPLE_BITS'(ro);
		res.peak_l = level_l;
		res.peak_r = level_r;
		return res;
	endfunction

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 19);
		if (roll < 15)
			return $urandom_range(1, 3);
		if (roll < 19)
			return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	function automatic smp_t rand_sample();
		longint x;
		case ($urandom_range(0, 9))
			0: begin
				return $urandom_range(0, 1) ? smp_t'(SMAX) : smp_t'(SMIN);
			end
			1: begin
				return smp_t'(int'($urandom_range(0, 4)) - 2);
			end
			2, 3: begin
				x = KNEE - KNEE_SPAN + longint'($urandom_range(0, 2 * KNEE_SPAN));
				return $urandom_range(0, 1) ? smp_t'(x) : smp_t'(-x);
			end
			4, 5: begin
				return smp_t'(int'($urandom_range(0, 1 << 16)) - (1 << 15));
			end
			default: begin
				return smp_t'($urandom());
			end
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_setting(int unsigned top, int w);
		logic [CFG_DATA_W-1:0] val;
		case ($urandom_range(0, 5))
			0: val = '0;
			1: val = top;
			2: val = (1 << w) - 1;
			default: val = $urandom_range(0, top);
		endcase
		// Now and then the write carries stray bits above the register width.
		if (w < CFG_DATA_W && $urandom_range(0, 7) == 0)
			val = val | ($urandom() << w);
		return val;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s expected %h got %h", $time, name, want, got);
		end
	endtask

	task automatic check_mix(input logic [OUT_TDATA_W-1:0] bus);
		mix_result_t want;
		if (pending_mixes.size() == 0) begin
			mismatches++;
			$display("%0t: result with no request pending, expected none got %h", $time, bus);
		end else begin
			want = pending_mixes.pop_front();
			check_field("left_out", want.left, bus[SAMPLE_BITS-1:0]);
			check_field("right_out", want.right, bus[2*SAMPLE_BITS-1:SAMPLE_BITS]);
			check_field("peak_left", want.peak_l, bus[2*SAMPLE_BITS+PEAK_W-1:2*SAMPLE_BITS]);
			check_field("peak_right", want.peak_r,
				bus[2*SAMPLE_BITS+2*PEAK_W-1:2*SAMPLE_BITS+PEAK_W]);
		end
	endtask

	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready)
			check_mix(m_axis_tdata);
		if (rx_hold > 0) begin
			m_axis_tready <= 1'b0;
			rx_hold--;
		end else if (rx_wait > 0) begin
			m_axis_tready <= 1'b0;
			rx_wait--;
		end else begin
			m_axis_tready <= 1'b1;
			if (!rx_eager && $urandom_range(0, 3) == 0)
				rx_wait = pick_gap();
		end
	end

	task automatic send_pair(input smp_t l, input smp_t r);
		int gap;
		s_axis_tdata <= {r, l};
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		pending_mixes.push_back(predict_mix(l, r));
		gap = (!tx_eager && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_until_drained();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_mixes.size() != 0)
			@(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			CFG_VINTAGE: rolloff_amt = val[VINT_W-1:0];
			CFG_GAIN_LEFT: gain_l = val[GAIN_W-1:0];
			CFG_GAIN_RIGHT: gain_r = val[GAIN_W-1:0];
			CFG_WIDTH: width_amt = val[WIDTH_W-1:0];
			CFG_DECAY: decay_amt = val[DECAY_W-1:0];
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic check_reset_defaults();
		send_pair('0, '0);
		send_pair(smp_t'(SMAX), smp_t'(SMAX));
		send_pair(smp_t'(SMIN), smp_t'(SMAX));
		wait_until_drained();
	endtask

	task automatic check_soft_limiter();
		// Unity gain and unity width pass each channel straight to the limiter.
		cfg_write(CFG_GAIN_LEFT, UNITY);
		cfg_write(CFG_GAIN_RIGHT, UNITY);
		cfg_write(CFG_WIDTH, UNITY);
		send_pair(smp_t'(KNEE), smp_t'(-KNEE));
		send_pair(smp_t'(KNEE + 1), smp_t'(-KNEE - 1));
		send_pair(smp_t'(SMAX), smp_t'(SMIN));
		send_pair(smp_t'(KNEE + KNEE_SPAN / 2), smp_t'(-KNEE - KNEE_SPAN / 2));
		wait_until_drained();
		cfg_write(CFG_GAIN_LEFT, GAIN_TOP);
		cfg_write(CFG_GAIN_RIGHT, GAIN_TOP);
		send_pair(smp_t'(SMAX / 2), smp_t'(SMIN / 2));
		wait_until_drained();
	endtask

	task automatic check_rolloff();
		cfg_write(CFG_GAIN_LEFT, UNITY);
		cfg_write(CFG_GAIN_RIGHT, UNITY);
		cfg_write(CFG_VINTAGE, ROLLOFF_ON);
		send_pair(smp_t'(SMAX), smp_t'(SMIN));
		send_pair(smp_t'(SMAX), smp_t'(SMIN));
		wait_until_drained();
		// Just below the threshold the smoother memory must hold its value.
		cfg_write(CFG_VINTAGE, ROLLOFF_ON - 1);
		send_pair('0, '0);
		send_pair('0, '0);
		wait_until_drained();
		cfg_write(CFG_VINTAGE, (1 << VINT_W) - 1);
		send_pair('0, '0);
		send_pair(smp_t'(SMIN), smp_t'(SMAX));
		wait_until_drained();
		cfg_write(CFG_VINTAGE, 0);
	endtask

	task automatic check_width_and_gain();
		cfg_write(CFG_WIDTH, 0);
		send_pair(smp_t'(SMAX), '0);
		wait_until_drained();
		cfg_write(CFG_WIDTH, (1 << WIDTH_W) - 1);
		send_pair(smp_t'(SMAX), smp_t'(SMIN));
		wait_until_drained();
		cfg_write(CFG_GAIN_LEFT, 0);
		cfg_write(CFG_GAIN_RIGHT, 0);
		send_pair(smp_t'(SMAX), smp_t'(SMAX));
		wait_until_drained();
		cfg_write(CFG_GAIN_LEFT, (1 << GAIN_W) - 1);
		cfg_write(CFG_GAIN_RIGHT, (1 << GAIN_W) - 1);
		cfg_write(CFG_WIDTH, WIDTH_TOP);
		send_pair(smp_t'(1), smp_t'(-1));
		wait_until_drained();
	endtask

	task automatic check_peak_meters();
		cfg_write(CFG_GAIN_LEFT, UNITY);
		cfg_write(CFG_GAIN_RIGHT, UNITY);
		cfg_write(CFG_WIDTH, UNITY);
		cfg_write(CFG_DECAY, 0);
		send_pair(smp_t'(SMAX), smp_t'(SMIN));
		send_pair('0, '0);
		wait_until_drained();
		cfg_write(CFG_DECAY, DECAY_TOP);
		send_pair('0, '0);
		wait_until_drained();
	endtask

	task automatic check_unused_indexes();
		int idx;
		for (idx = int'(CFG_DECAY) + 1; idx < (1 << CFG_IDX_W); idx++)
			cfg_write(idx[CFG_IDX_W-1:0], $urandom());
		send_pair(rand_sample(), rand_sample());
		wait_until_drained();
	endtask

	task automatic check_output_backpressure();
		int n;
		// The output side refuses results for a long stretch while requests keep coming.
		tx_eager = 1'b1;
		rx_hold = 300;
		for (n = 0; n < 12; n++)
			send_pair(rand_sample(), rand_sample());
		tx_eager = 1'b0;
		wait_until_drained();
	endtask

	task automatic check_lockstep();
		int n;
		for (n = 0; n < 8; n++) begin
			send_pair(rand_sample(), rand_sample());
			wait_until_drained();
		end
	endtask

	task automatic check_random_mixes();
		int phase;
		int n;
		for (phase = 0; phase < 8; phase++) begin
			wait_until_drained();
			cfg_write(CFG_VINTAGE, pick_setting(ROLLOFF_TOP, VINT_W));
			cfg_write(CFG_GAIN_LEFT, pick_setting(GAIN_TOP, GAIN_W));
			cfg_write(CFG_GAIN_RIGHT, pick_setting(GAIN_TOP, GAIN_W));
			cfg_write(CFG_WIDTH, pick_setting(WIDTH_TOP, WIDTH_W));
			cfg_write(CFG_DECAY, pick_setting(DECAY_TOP, DECAY_W));
			tx_eager = (phase == 3);
			rx_eager = (phase == 3);
			for (n = 0; n < 50; n++)
				send_pair(rand_sample(), rand_sample());
		end
		tx_eager = 1'b0;
		rx_eager = 1'b0;
		wait_until_drained();
	endtask

	initial begin
		build_knee_curve();
		rolloff_amt = '0;
		gain_l = GAIN_DEFAULT;
		gain_r = GAIN_DEFAULT;
		width_amt = WIDTH_DEFAULT;
		decay_amt = DECAY_DEFAULT;
		mem_l = '0;
		mem_r = '0;
		level_l = '0;
		level_r = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		check_reset_defaults();
		check_soft_limiter();
		check_rolloff();
		check_width_and_gain();
		check_peak_meters();
		check_unused_indexes();
		check_output_backpressure();
		check_lockstep();
		check_random_mixes();
		wait_until_drained();
		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/sos_pkg.sv
rtl/core/sos_cfg.sv
rtl/core/sos_front.sv
rtl/core/sos_queue.sv
rtl/core/sos_back.sv
rtl/core/stereo_master_output_stage.sv
tb/stereo_master_output_stage_test.sv
